// ----- hw/rtl/motor_bridge_fault_supervisor_unit_defines.svh -----
// Assertion macros shared by the motor bridge fault supervisor RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MOTOR_BRIDGE_FAULT_SUPERVISOR_UNIT_DEFINES_SVH
`define MOTOR_BRIDGE_FAULT_SUPERVISOR_UNIT_DEFINES_SVH

// Implication checked every clock, masked while reset is asserted.
`define MBFS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define MBFS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/mbfs_pkg.sv -----
// Types and constants for the motor bridge fault supervisor.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbfs_pkg;

	localparam int unsigned NUM_REGS   = 6;
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned FAULT_W    = 6;
	localparam int unsigned CUR_W      = 21;
	localparam int unsigned LIMIT_W    = 20;
	localparam int unsigned MV_W       = 16;
	localparam int unsigned TICK_W     = 32;

	// register indexes
	localparam logic [2:0] REG_INSTANT_LIMIT   = 3'd0;
	localparam logic [2:0] REG_SUSTAINED_LIMIT = 3'd1;
	localparam logic [2:0] REG_SUSTAINED_WIN   = 3'd2;
	localparam logic [2:0] REG_BUS_MAX         = 3'd3;
	localparam logic [2:0] REG_BUS_MIN         = 3'd4;
	localparam logic [2:0] REG_SUPERVISOR_ON   = 3'd5;

	// transaction function codes
	localparam logic FUNC_POLL  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// fault bits
	localparam logic [FAULT_W-1:0] FLT_NONE = 6'h00;
	localparam logic [FAULT_W-1:0] FLT_OCA  = 6'h01;
	localparam logic [FAULT_W-1:0] FLT_OCB  = 6'h02;
	localparam logic [FAULT_W-1:0] FLT_SUST = 6'h04;
	localparam logic [FAULT_W-1:0] FLT_OVV  = 6'h08;
	localparam logic [FAULT_W-1:0] FLT_UNV  = 6'h10;
	localparam logic [FAULT_W-1:0] FLT_SENS = 6'h20;

	typedef struct packed {
		logic [LIMIT_W-1:0] instant_limit_ma;
		logic [LIMIT_W-1:0] cont_limit_ma;
		logic [TICK_W-1:0]  cont_window_ms;
		logic [MV_W-1:0]    bus_max_mv;
		logic [MV_W-1:0]    bus_min_mv;
		logic               supervisor_on;
	} cfg_t;

	typedef struct packed {
		logic                     func;
		logic                     loop_running;
		logic signed [CUR_W-1:0]  phase_a_ma;
		logic signed [CUR_W-1:0]  phase_b_ma;
		logic [MV_W-1:0]          bus_mv;
		logic [TICK_W-1:0]        now_ms;
	} item_t;

	typedef struct packed {
		logic [FAULT_W-1:0] fault_mask;
		logic               clear_ok;
		logic               bridge_off;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mbfs_regs.sv -----
// APB-style configuration register file of the fault supervisor.
// Depends on mbfs_pkg.
`default_nettype none

module mbfs_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mbfs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output mbfs_pkg::cfg_t                   cfg
);
	import mbfs_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign idx   = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;   // pready is tied high

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.instant_limit_ma <= 20'd20000;
			cfg_q.cont_limit_ma    <= 20'd10000;
			cfg_q.cont_window_ms   <= 32'd100;
			cfg_q.bus_max_mv       <= 16'd30000;
			cfg_q.bus_min_mv       <= 16'd8000;
			cfg_q.supervisor_on    <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				REG_INSTANT_LIMIT:   cfg_q.instant_limit_ma <= pwdata[LIMIT_W-1:0];
				REG_SUSTAINED_LIMIT: cfg_q.cont_limit_ma    <= pwdata[LIMIT_W-1:0];
				REG_SUSTAINED_WIN:   cfg_q.cont_window_ms   <= pwdata[TICK_W-1:0];
				REG_BUS_MAX:         cfg_q.bus_max_mv       <= pwdata[MV_W-1:0];
				REG_BUS_MIN:         cfg_q.bus_min_mv       <= pwdata[MV_W-1:0];
				REG_SUPERVISOR_ON:   cfg_q.supervisor_on    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_INSTANT_LIMIT:   prdata = {12'd0, cfg_q.instant_limit_ma};
			REG_SUSTAINED_LIMIT: prdata = {12'd0, cfg_q.cont_limit_ma};
			REG_SUSTAINED_WIN:   prdata = cfg_q.cont_window_ms;
			REG_BUS_MAX:         prdata = {16'd0, cfg_q.bus_max_mv};
			REG_BUS_MIN:         prdata = {16'd0, cfg_q.bus_min_mv};
			REG_SUPERVISOR_ON:   prdata = {31'd0, cfg_q.supervisor_on};
			default:             prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mbfs_eval.sv -----
// Fault evaluation logic and supervisor state (latched faults, excursion
// start tick, bus check countdown). Depends on mbfs_pkg and the defines header.
`default_nettype none
`include "motor_bridge_fault_supervisor_unit_defines.svh"

module mbfs_eval #(
	parameter int unsigned BUS_CHECK_INTERVAL = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire mbfs_pkg::cfg_t    cfg,
	input  wire mbfs_pkg::item_t   item,
	output mbfs_pkg::result_t      res
);
	import mbfs_pkg::*;

	logic [FAULT_W-1:0] faults_q, faults_d;
	logic [TICK_W-1:0]  exc_start_q, exc_start_d;
	logic [MV_W-1:0]    bus_cnt_q, bus_cnt_d;

	logic [CUR_W-1:0]   raw_a, raw_b, mag_a, mag_b, mag_hi;
	logic [CUR_W-1:0]   inst_lim, sust_lim;
	logic [TICK_W-1:0]  elapsed;
	logic [FAULT_W-1:0] newf;
	logic               clr;
	logic               bus_ok;

	assign raw_a    = item.phase_a_ma;
	assign raw_b    = item.phase_b_ma;
	// most negative code maps to 2^20, still representable unsigned
	assign mag_a    = raw_a[CUR_W-1] ? (~raw_a + 21'd1) : raw_a;
	assign mag_b    = raw_b[CUR_W-1] ? (~raw_b + 21'd1) : raw_b;
	assign mag_hi   = (mag_a > mag_b) ? mag_a : mag_b;
	assign inst_lim = {1'b0, cfg.instant_limit_ma};
	assign sust_lim = {1'b0, cfg.cont_limit_ma};
	assign elapsed  = item.now_ms - exc_start_q;   // wraps mod 2^32
	assign bus_ok   = (item.bus_mv <= cfg.bus_max_mv) && (item.bus_mv >= cfg.bus_min_mv);

	always_comb begin
		newf        = FLT_NONE;
		clr         = 1'b0;
		faults_d    = faults_q;
		exc_start_d = exc_start_q;
		bus_cnt_d   = bus_cnt_q;
		if (item.func == FUNC_POLL) begin
			if (cfg.supervisor_on && (faults_q == FLT_NONE)) begin
				if (!item.loop_running) begin
					newf = FLT_SENS;
				end else if (mag_a > inst_lim) begin
					newf = FLT_OCA;
				end else if (mag_b > inst_lim) begin
					newf = FLT_OCB;
				end else begin
					if (mag_hi > sust_lim) begin
						if (exc_start_q == '0) begin
							// zero marks "no excursion", so tick 0 is held as 1
							exc_start_d = (item.now_ms == '0) ? 32'd1 : item.now_ms;
						end else if (elapsed > cfg.cont_window_ms) begin
							newf = FLT_SUST;
						end
					end else begin
						exc_start_d = '0;
					end
					if (newf == FLT_NONE) begin
						if (bus_cnt_q == '0) begin
							bus_cnt_d = MV_W'(BUS_CHECK_INTERVAL);
							if (item.bus_mv > cfg.bus_max_mv) begin
								newf = FLT_OVV;
							end else if (item.bus_mv < cfg.bus_min_mv) begin
								newf = FLT_UNV;
							end
						end else begin
							bus_cnt_d = bus_cnt_q - 16'd1;
						end
					end
				end
				faults_d = faults_q | newf;
			end
		end else begin
			if (faults_q == FLT_NONE) begin
				clr = 1'b1;
			end else if (item.loop_running && (mag_a <= sust_lim) && (mag_b <= sust_lim)
					&& bus_ok) begin
				faults_d    = FLT_NONE;
				exc_start_d = '0;
				clr         = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			faults_q    <= FLT_NONE;
			exc_start_q <= '0;
			bus_cnt_q   <= '0;
		end else if (en) begin
			faults_q    <= faults_d;
			exc_start_q <= exc_start_d;
			bus_cnt_q   <= bus_cnt_d;
		end
	end

	assign res.fault_mask = faults_d;
	assign res.clear_ok   = clr;
	assign res.bridge_off = (newf != FLT_NONE);

	`MBFS_ASSERT_NXT(a_faults_hold, !en, $stable(faults_q), "faults changed without a transaction")
	`MBFS_ASSERT_NXT(a_trip_latches, en && res.bridge_off, faults_q != FLT_NONE, "trip not latched")
	`MBFS_ASSERT_NXT(a_clear_resets_exc, en && (item.func == FUNC_CLEAR) && clr
		&& (faults_q != FLT_NONE), exc_start_q == '0, "excursion start kept after clear")

endmodule

`default_nettype wire

// ----- hw/rtl/motor_bridge_fault_supervisor_unit.sv -----
// Top level of the motor bridge fault supervisor: input register, evaluation,
// result register and configuration port. Depends on mbfs_pkg, mbfs_regs, mbfs_eval.
`default_nettype none
`include "motor_bridge_fault_supervisor_unit_defines.svh"

// Latching fault supervisor for a motor bridge sensed on two phases. Each
// input transaction is either a poll (func = 0) or a clear request (func = 1)
// and produces exactly one result transaction: the latched fault mask after
// the transaction, clear_ok (clear requests only) and bridge_off, a one-item
// pulse raised by the poll that trips a fault. A poll checks, in priority
// order, sensor failure (loop not running), instantaneous overcurrent on
// phase A then B, sustained overcurrent of the larger magnitude, and every
// BUS_CHECK_INTERVAL+1 current-clean polls the bus over/undervoltage limits.
// Once a fault is latched, polls only report it until a clear succeeds.
// Throughput is one transaction per clock while the result channel is not
// stalled: the transaction is captured in an input register, all checks are
// one pass of compares plus one 32-bit tick subtraction, and the state and
// result registers load at the same edge as the transaction advances.
// in_ready stays high while the input register is empty or can move into the
// result register, so a stalled consumer holds one result plus one item in
// the input register.
// Configuration registers sit at byte addresses 4*i (APB, pready tied high);
// write them only while the block is idle.
module motor_bridge_fault_supervisor_unit #(
	parameter int unsigned BUS_CHECK_INTERVAL = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mbfs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// input channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        func,
	input  wire logic                        loop_running,
	input  wire logic signed [20:0]          phase_a_ma,
	input  wire logic signed [20:0]          phase_b_ma,
	input  wire logic [15:0]                 bus_mv,
	input  wire logic [31:0]                 now_ms,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [5:0]                       fault_mask,
	output logic                             clear_ok,
	output logic                             bridge_off
);
	import mbfs_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;

	assign pready = 1'b1;

	mbfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// stage 1 moves into the result register when that slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func         <= func;
			item_s1.loop_running <= loop_running;
			item_s1.phase_a_ma   <= phase_a_ma;
			item_s1.phase_b_ma   <= phase_b_ma;
			item_s1.bus_mv       <= bus_mv;
			item_s1.now_ms       <= now_ms;
		end
	end

	mbfs_eval #(
		.BUS_CHECK_INTERVAL (BUS_CHECK_INTERVAL)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign fault_mask = res_q.fault_mask;
	assign clear_ok   = res_q.clear_ok;
	assign bridge_off = res_q.bridge_off;

	`MBFS_ASSERT_IMP(a_trip_has_fault, out_valid_q && res_q.bridge_off,
		res_q.fault_mask != FLT_NONE, "bridge_off with empty fault mask")
	`MBFS_ASSERT_IMP(a_clear_empties, out_valid_q && res_q.clear_ok,
		res_q.fault_mask == FLT_NONE, "clear_ok with faults latched")
	`MBFS_ASSERT_IMP(a_no_overrun, valid_s1 && out_valid_q && !out_ready,
		!in_ready, "input accepted while both stages are full and stalled")

endmodule

`default_nettype wire
